// File: rtl/core/jbt_pkg.sv
// jbt_pkg: types, token codes and byte classifiers for the json byte tokenizer
// no dependencies; imported by every module under rtl/core
package jbt_pkg;

    localparam logic [2:0] KIND_OPEN_BRACE    = 3'd0;
    localparam logic [2:0] KIND_CLOSE_BRACE   = 3'd1;
    localparam logic [2:0] KIND_OPEN_BRACKET  = 3'd2;
    localparam logic [2:0] KIND_CLOSE_BRACKET = 3'd3;
    localparam logic [2:0] KIND_COLON         = 3'd4;
    localparam logic [2:0] KIND_COMMA         = 3'd5;
    localparam logic [2:0] KIND_STR_BYTE      = 3'd6;
    localparam logic [2:0] KIND_STR_END       = 3'd7;

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_TAB       = 8'h09;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_BARE   = 2'd2
    } lex_mode_t;

    // one result beat
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] sbyte;
        logic       quoted;
    } tok_res_t;

    // work for one input byte: one result, or a string end followed by punctuation
    typedef struct packed {
        logic       two;
        tok_res_t   res0;
        logic [2:0] kind1;
    } tok_op_t;

    function automatic logic is_punct(input logic [7:0] b);
        return (b == 8'h7B) || (b == 8'h7D) || (b == 8'h5B) || (b == 8'h5D) ||
               (b == 8'h3A) || (b == 8'h2C);
    endfunction

    function automatic logic [2:0] punct_kind(input logic [7:0] b);
        logic [2:0] k;
        k = KIND_COMMA;
        unique case (b)
            8'h7B:   k = KIND_OPEN_BRACE;
            8'h7D:   k = KIND_CLOSE_BRACE;
            8'h5B:   k = KIND_OPEN_BRACKET;
            8'h5D:   k = KIND_CLOSE_BRACKET;
            8'h3A:   k = KIND_COLON;
            default: k = KIND_COMMA;
        endcase
        return k;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CHAR_SPACE) || (b == CHAR_CR) || (b == CHAR_LF) || (b == CHAR_TAB);
    endfunction

endpackage

// File: rtl/core/jbt_front.sv
// jbt_front: accepts text bytes, tracks lexer mode and escape, builds result ops
// depends on jbt_pkg
module jbt_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_text_byte,
    input  logic             q_full,
    output logic             push,
    output jbt_pkg::tok_op_t push_op
);
    import jbt_pkg::*;

    lex_mode_t mode_reg, mode_next;
    logic      esc_reg, esc_next;
    logic      has_res;
    logic      accept;
    logic      pk, blank, quote, bslash, printable;

    assign s_ready   = !q_full;
    assign accept    = s_valid && !q_full;
    assign pk        = is_punct(s_text_byte);
    assign blank     = is_blank(s_text_byte);
    assign quote     = (s_text_byte == CHAR_QUOTE);
    assign bslash    = (s_text_byte == CHAR_BACKSLASH);
    assign printable = (s_text_byte >= CHAR_SPACE);

    // next state
    always_comb begin
        mode_next = mode_reg;
        esc_next  = esc_reg;
        unique case (mode_reg)
            MODE_BARE: begin
                if (quote) begin
                    mode_next = MODE_QUOTED;
                    esc_next  = 1'b0;
                end else if (pk || blank) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_QUOTED: begin
                if (!esc_reg && quote) begin
                    mode_next = MODE_IDLE;
                end else if (!esc_reg && bslash) begin
                    esc_next = 1'b1;
                end else begin
                    esc_next = 1'b0;
                end
            end
            default: begin
                mode_next = MODE_IDLE;
                if (pk) begin
                    mode_next = MODE_IDLE;
                end else if (quote) begin
                    mode_next = MODE_QUOTED;
                    esc_next  = 1'b0;
                end else if (!blank) begin
                    mode_next = MODE_BARE;
                end
            end
        endcase
    end

    // result op
    always_comb begin
        has_res            = 1'b0;
        push_op.two        = 1'b0;
        push_op.res0.kind  = KIND_STR_BYTE;
        push_op.res0.sbyte = 8'd0;
        push_op.res0.quoted = 1'b0;
        push_op.kind1      = punct_kind(s_text_byte);
        unique case (mode_reg)
            MODE_BARE: begin
                if (pk || quote || blank) begin
                    has_res           = 1'b1;
                    push_op.res0.kind = KIND_STR_END;
                    push_op.two       = pk;
                end else if (printable) begin
                    has_res            = 1'b1;
                    push_op.res0.sbyte = s_text_byte;
                end
            end
            MODE_QUOTED: begin
                push_op.res0.quoted = 1'b1;
                if (!esc_reg && quote) begin
                    has_res           = 1'b1;
                    push_op.res0.kind = KIND_STR_END;
                end else if (!esc_reg && bslash) begin
                    has_res = 1'b0;
                end else if (printable) begin
                    has_res            = 1'b1;
                    push_op.res0.sbyte = s_text_byte;
                end
            end
            default: begin
                if (pk) begin
                    has_res           = 1'b1;
                    push_op.res0.kind = punct_kind(s_text_byte);
                end else if (!quote && !blank && printable) begin
                    has_res            = 1'b1;
                    push_op.res0.sbyte = s_text_byte;
                end
            end
        endcase
    end

    assign push = accept && has_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            esc_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            esc_reg  <= esc_next;
        end
    end

endmodule

// File: rtl/core/jbt_queue.sv
// jbt_queue: two-entry op queue between front and back
// depends on jbt_pkg
module jbt_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  jbt_pkg::tok_op_t push_op,
    output logic             full,
    input  logic             pop,
    output logic             q_valid,
    output jbt_pkg::tok_op_t head_op
);
    import jbt_pkg::*;

    tok_op_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign head_op = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/core/jbt_back.sv
// jbt_back: takes ops from the queue and drives result beats from an output register
// depends on jbt_pkg
module jbt_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  jbt_pkg::tok_op_t head_op,
    output logic             pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [2:0]       m_token_kind,
    output logic [7:0]       m_string_byte,
    output logic             m_was_quoted,
    output logic             m_last_of_run
);
    import jbt_pkg::*;

    logic       m_valid_reg, m_valid_next;
    logic       pend_reg, pend_next;
    logic [2:0] pend_kind_reg, pend_kind_next;
    tok_res_t   out_reg, out_next;
    logic       last_reg, last_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    // second beat of a two-result op goes before the next op
    assign pop      = out_free && !pend_reg && q_valid;

    always_comb begin
        m_valid_next   = m_valid_reg && !m_ready;
        pend_next      = pend_reg;
        pend_kind_next = pend_kind_reg;
        out_next       = out_reg;
        last_next      = last_reg;
        if (out_free) begin
            if (pend_reg) begin
                m_valid_next   = 1'b1;
                pend_next      = 1'b0;
                out_next.kind  = pend_kind_reg;
                out_next.sbyte = 8'd0;
                out_next.quoted = 1'b0;
                last_next      = 1'b1;
            end else if (q_valid) begin
                m_valid_next   = 1'b1;
                pend_next      = head_op.two;
                pend_kind_next = head_op.kind1;
                out_next       = head_op.res0;
                last_next      = !head_op.two;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg       <= out_next;
        last_reg      <= last_next;
        pend_kind_reg <= pend_kind_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_token_kind  = out_reg.kind;
    assign m_string_byte = out_reg.sbyte;
    assign m_was_quoted  = out_reg.quoted;
    assign m_last_of_run = last_reg;

endmodule

// File: rtl/core/json_byte_tokenizer_top.sv
// channel   dir  handshake           payload
// s_        in   s_valid / s_ready   s_text_byte[7:0]
// m_        out  m_valid / m_ready   m_token_kind[2:0], m_string_byte[7:0],
//                                    m_was_quoted, m_last_of_run
//
// one text byte is accepted per cycle while the op queue is not full; a
// byte that ends a bare string with punctuation gives two beats, and the
// back end sends both before it takes the next op. results pass through a
// queue slot and then the output register.
// aresetn is synchronous active low and returns the lexer to idle mode.
// s_ready drops only when the two-entry op queue is full; a stalled m_ready
// fills the queue before it reaches the input side.
// top level: instantiates jbt_front, jbt_queue and jbt_back; depends on jbt_pkg
module json_byte_tokenizer_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_token_kind,
    output logic [7:0] m_string_byte,
    output logic       m_was_quoted,
    output logic       m_last_of_run
);
    import jbt_pkg::*;

    logic    push, pop, q_full, q_valid;
    tok_op_t push_op, head_op;

    jbt_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_text_byte (s_text_byte),
        .q_full      (q_full),
        .push        (push),
        .push_op     (push_op)
    );

    jbt_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .head_op (head_op)
    );

    jbt_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .head_op       (head_op),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_string_byte (m_string_byte),
        .m_was_quoted  (m_was_quoted),
        .m_last_of_run (m_last_of_run)
    );

endmodule
